// ===== rtl/nss_pkg.sv =====
// Package: types and constants shared by the needle solenoid sequencer.
package nss_pkg;

    // Signed pixel width: covers store reach, window margins and carriage offsets.
    localparam int PIX_W = 10;

    localparam logic signed [PIX_W-1:0] LEFT_MARGIN  = 10'sd12;
    localparam logic signed [PIX_W-1:0] RIGHT_MARGIN = 10'sd12;
    localparam logic signed [PIX_W-1:0] RIGHT_END    = 10'sd255;

    // Carriage offsets in needle steps
    localparam logic signed [PIX_W-1:0] OFF_RIGHT_G   = 10'sd8;
    localparam logic signed [PIX_W-1:0] OFF_RIGHT_STD = 10'sd40;
    localparam logic signed [PIX_W-1:0] OFF_LEFT_G    = 10'sd32;
    localparam logic signed [PIX_W-1:0] OFF_LEFT_STD  = 10'sd16;
    localparam logic signed [PIX_W-1:0] ADJ_RIGHT_L   = 10'sd8;
    localparam logic signed [PIX_W-1:0] ADJ_LEFT_L    = 10'sd16;

    localparam logic [7:0] LINE_COUNTER_RESET = 8'd255;

    typedef enum logic [1:0] {
        MODE_INIT    = 2'd0,
        MODE_READY   = 2'd1,
        MODE_OPERATE = 2'd2,
        MODE_TEST    = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        OP_POSITION   = 3'd0,
        OP_START_JOB  = 3'd1,
        OP_START_TEST = 3'd2,
        OP_LINE       = 3'd3,
        OP_LAST_LINE  = 3'd4,
        OP_WRITE_BYTE = 3'd5
    } t_opcode;

    localparam logic [1:0] TRAVEL_LEFT  = 2'd0;
    localparam logic [1:0] TRAVEL_RIGHT = 2'd1;

    localparam logic [1:0] HALL_LEFT = 2'd1;

    localparam logic [1:0] KIND_L = 2'd1;
    localparam logic [1:0] KIND_G = 2'd2;

    localparam logic [1:0] CFG_FIRST_NEEDLE = 2'd0;
    localparam logic [1:0] CFG_LAST_NEEDLE  = 2'd1;
    localparam logic [1:0] CFG_REPORT_MOVE  = 2'd2;

    typedef struct packed {
        logic       accepted;
        logic       solenoid_write;
        logic [3:0] solenoid_index;
        logic       solenoid_level;
        logic       release_all;
        logic       line_request;
        logic [7:0] requested_line;
        logic       report_state;
        logic       report_initial;
        t_mode      machine_state;
        logic       work_finished;
    } t_result;

endpackage

// ===== rtl/needle_solenoid_sequencer_core.sv =====
// Top level: needle solenoid sequencer core with input and result registers.
//
// Usage
//   Input channel (i_valid / o_ready) carries one event or host command per
//   transfer: carriage position events, start job, start test, line
//   delivered, last line and bitmap byte writes. Every transfer produces
//   exactly one result on the output channel (o_valid / i_ready) carrying
//   the solenoid action, line request, report flags and the machine state.
//   After an input transfer the item sits in the input register while the
//   decode settles, and the result register takes it once that register is
//   empty or being drained; o_valid then rises and the result can transfer.
//   Throughput is one item per cycle; the input register refills while a
//   finished result waits, and the stage only holds when the result register
//   is full and the receiver does not take it.
//   When the receiver stalls, hold the result and the queued item; o_ready
//   drops only once both stages are occupied.
//   Configuration writes (i_cfg_we) take effect at once and are expected
//   only while the pipeline is empty.
//   Synchronous reset returns the sequencer to init, line counter to 255,
//   clears the line flags and empties both stages. The bitmap store is not
//   cleared; bytes must be written before a pixel reads them.
module needle_solenoid_sequencer_core
    import nss_pkg::*;
#(
    parameter int NEEDLE_COUNT = 200
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // configuration
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data,
    // input channel
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [2:0] i_opcode,
    input  logic [7:0] i_position,
    input  logic [1:0] i_travel,
    input  logic [1:0] i_hall_side,
    input  logic       i_belt_shifted,
    input  logic [1:0] i_carriage_kind,
    input  logic [7:0] i_line_number,
    input  logic [4:0] i_byte_index,
    input  logic [7:0] i_byte_value,
    // result channel
    output logic       o_valid,
    input  logic       i_ready,
    output logic       o_accepted,
    output logic       o_solenoid_write,
    output logic [3:0] o_solenoid_index,
    output logic       o_solenoid_level,
    output logic       o_release_all,
    output logic       o_line_request,
    output logic [7:0] o_requested_line,
    output logic       o_report_state,
    output logic       o_report_initial,
    output logic [1:0] o_machine_state,
    output logic       o_work_finished
);

    localparam int STORE_BYTES = (NEEDLE_COUNT + 7) / 8;
    localparam int IDX_W       = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
    localparam logic [5:0] STORE_BYTES_W = 6'(STORE_BYTES);
    localparam logic signed [PIX_W-1:0] STORE_PIX = PIX_W'(STORE_BYTES * 8);
    localparam logic [8:0] NEEDLE_COUNT_W = 9'(NEEDLE_COUNT);

    // Configuration registers
    logic [7:0] r_first_needle;
    logic [7:0] r_last_needle;
    logic       r_report_move;

    // Sequencer state
    t_mode      r_mode,         n_mode;
    logic [7:0] r_op_prev,      n_op_prev;
    logic [7:0] r_test_prev,    n_test_prev;
    logic [7:0] r_line_counter, n_line_counter;
    logic       r_awaiting,     n_awaiting;
    logic       r_final,        n_final;
    logic       r_touched,      n_touched;

    logic [7:0] r_store [STORE_BYTES];

    // Input register
    logic       r_in_valid;
    logic [2:0] r_opcode;
    logic [7:0] r_position;
    logic [1:0] r_travel;
    logic [1:0] r_hall_side;
    logic       r_belt_shifted;
    logic [1:0] r_carriage_kind;
    logic [7:0] r_line_number;
    logic [4:0] r_byte_index;
    logic [7:0] r_byte_value;

    // Result register
    logic    r_out_valid;
    t_result r_out, n_out;

    logic w_adv;
    logic w_take;

    assign w_adv   = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || w_adv;
    assign w_take  = i_valid && o_ready;

    // Configuration port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_needle <= '0;
            r_last_needle  <= '0;
            r_report_move  <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_FIRST_NEEDLE: r_first_needle <= i_cfg_data;
                CFG_LAST_NEEDLE:  r_last_needle  <= i_cfg_data;
                CFG_REPORT_MOVE:  r_report_move  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Input register: refill whenever the held item moves on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_opcode        <= i_opcode;
            r_position      <= i_position;
            r_travel        <= i_travel;
            r_hall_side     <= i_hall_side;
            r_belt_shifted  <= i_belt_shifted;
            r_carriage_kind <= i_carriage_kind;
            r_line_number   <= i_line_number;
            r_byte_index    <= i_byte_index;
            r_byte_value    <= i_byte_value;
        end
    end

    // Carriage position to pixel and solenoid
    logic                    w_loc_ok;
    logic signed [PIX_W-1:0] w_pos_s;
    logic signed [PIX_W-1:0] w_off;
    logic signed [PIX_W-1:0] w_pixel;
    logic [3:0]              w_sol;
    logic [3:0]              w_sol_shift;
    logic signed [PIX_W-1:0] w_first_s;
    logic signed [PIX_W-1:0] w_last_s;
    logic                    w_in_margin;
    logic                    w_in_window;
    logic                    w_in_store;
    logic [IDX_W-1:0]        w_byte_sel;
    logic [7:0]              w_byte;
    logic                    w_level;
    logic                    w_wr_ok;

    assign w_pos_s     = signed'({2'b00, r_position});
    assign w_sol_shift = {~r_position[3], r_position[2:0]};

    always_comb begin
        w_loc_ok = 1'b0;
        w_off    = '0;
        w_pixel  = '0;
        w_sol    = '0;
        if (r_travel == TRAVEL_RIGHT) begin
            w_off    = (r_carriage_kind == KIND_G) ? OFF_RIGHT_G : OFF_RIGHT_STD;
            w_loc_ok = (w_pos_s >= w_off);
            w_pixel  = w_pos_s - w_off;
            if (r_carriage_kind == KIND_L) begin
                w_pixel = w_pixel + ADJ_RIGHT_L;
            end
            w_sol = r_belt_shifted ? w_sol_shift : r_position[3:0];
        end else if (r_travel == TRAVEL_LEFT) begin
            w_off    = (r_carriage_kind == KIND_G) ? OFF_LEFT_G : OFF_LEFT_STD;
            w_loc_ok = (w_pos_s <= (RIGHT_END - w_off));
            w_pixel  = w_pos_s - w_off;
            if (r_carriage_kind == KIND_L) begin
                w_pixel = w_pixel - ADJ_LEFT_L;
            end
            w_sol = r_belt_shifted ? r_position[3:0] : w_sol_shift;
        end
    end

    assign w_first_s   = signed'({2'b00, r_first_needle});
    assign w_last_s    = signed'({2'b00, r_last_needle});
    assign w_in_margin = (w_pixel >= (w_first_s - LEFT_MARGIN)) &&
                         (w_pixel <= (w_last_s + RIGHT_MARGIN));
    assign w_in_window = (w_pixel >= w_first_s) && (w_pixel <= w_last_s);
    assign w_in_store  = (w_pixel >= 0) && (w_pixel < STORE_PIX);
    assign w_byte_sel  = w_pixel[3 +: IDX_W];
    assign w_byte      = r_store[w_byte_sel];
    // Pixels outside the store read as released
    assign w_level     = w_in_store ? w_byte[w_pixel[2:0]] : 1'b1;
    assign w_wr_ok     = ({1'b0, r_byte_index} < STORE_BYTES_W);

    // Next state and result
    always_comb begin
        n_mode         = r_mode;
        n_op_prev      = r_op_prev;
        n_test_prev    = r_test_prev;
        n_line_counter = r_line_counter;
        n_awaiting     = r_awaiting;
        n_final        = r_final;
        n_touched      = r_touched;
        n_out          = '0;

        case (r_opcode)
            OP_POSITION: begin
                unique case (r_mode)
                    MODE_INIT: begin
                        if (r_travel == TRAVEL_RIGHT && r_hall_side == HALL_LEFT) begin
                            n_mode               = MODE_READY;
                            n_out.release_all    = 1'b1;
                            n_out.report_state   = 1'b1;
                            n_out.report_initial = 1'b1;
                        end
                    end
                    MODE_OPERATE: begin
                        if (r_position != r_op_prev) begin
                            n_op_prev = r_position;
                            if (r_report_move) begin
                                n_out.report_state   = 1'b1;
                                n_out.report_initial = 1'b1;
                            end
                            if (w_loc_ok) begin
                                n_out.solenoid_write = 1'b1;
                                n_out.solenoid_index = w_sol;
                                if (w_in_margin) begin
                                    if (w_in_window) begin
                                        n_touched = 1'b1;
                                    end
                                    n_out.solenoid_level = w_level;
                                end else begin
                                    // Outside the needle window: release, then line handling
                                    n_out.solenoid_level = 1'b1;
                                    if (r_touched) begin
                                        n_touched = 1'b0;
                                        if (!r_awaiting && !r_final) begin
                                            n_line_counter       = r_line_counter + 8'd1;
                                            n_awaiting           = 1'b1;
                                            n_out.line_request   = 1'b1;
                                            n_out.requested_line = r_line_counter + 8'd1;
                                        end else if (r_final) begin
                                            n_mode              = MODE_READY;
                                            n_out.release_all   = 1'b1;
                                            n_out.work_finished = 1'b1;
                                        end
                                    end
                                end
                            end
                        end
                    end
                    MODE_TEST: begin
                        if (r_position != r_test_prev) begin
                            n_test_prev        = r_position;
                            n_out.report_state = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            OP_START_JOB: begin
                if (r_mode == MODE_READY && ({1'b0, r_last_needle} < NEEDLE_COUNT_W) &&
                    (r_first_needle < r_last_needle)) begin
                    // Counter wraps from its reset value, so the first request is line 0
                    n_mode               = MODE_OPERATE;
                    n_line_counter       = LINE_COUNTER_RESET + 8'd1;
                    n_awaiting           = 1'b1;
                    n_final              = 1'b0;
                    n_touched            = 1'b0;
                    n_out.accepted       = 1'b1;
                    n_out.line_request   = 1'b1;
                    n_out.requested_line = LINE_COUNTER_RESET + 8'd1;
                end
            end
            OP_START_TEST: begin
                if (r_mode == MODE_INIT || r_mode == MODE_READY) begin
                    n_mode         = MODE_TEST;
                    n_out.accepted = 1'b1;
                end
            end
            OP_LINE: begin
                if (r_awaiting) begin
                    if (r_line_number == r_line_counter) begin
                        n_awaiting     = 1'b0;
                        n_out.accepted = 1'b1;
                    end else begin
                        n_out.line_request   = 1'b1;
                        n_out.requested_line = r_line_counter;
                    end
                end
            end
            OP_LAST_LINE: begin
                n_final = 1'b1;
            end
            default: ;
        endcase

        n_out.machine_state = n_mode;
    end

    // State register: advance only when the item moves into the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode         <= MODE_INIT;
            r_op_prev      <= '0;
            r_test_prev    <= '0;
            r_line_counter <= LINE_COUNTER_RESET;
            r_awaiting     <= 1'b0;
            r_final        <= 1'b0;
            r_touched      <= 1'b0;
        end else if (w_adv) begin
            r_mode         <= n_mode;
            r_op_prev      <= n_op_prev;
            r_test_prev    <= n_test_prev;
            r_line_counter <= n_line_counter;
            r_awaiting     <= n_awaiting;
            r_final        <= n_final;
            r_touched      <= n_touched;
        end
    end

    // Bitmap store, no reset
    always_ff @(posedge i_clk) begin
        if (w_adv && r_opcode == OP_WRITE_BYTE && w_wr_ok) begin
            r_store[r_byte_index[IDX_W-1:0]] <= r_byte_value;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= n_out;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_accepted       = r_out.accepted;
    assign o_solenoid_write = r_out.solenoid_write;
    assign o_solenoid_index = r_out.solenoid_index;
    assign o_solenoid_level = r_out.solenoid_level;
    assign o_release_all    = r_out.release_all;
    assign o_line_request   = r_out.line_request;
    assign o_requested_line = r_out.requested_line;
    assign o_report_state   = r_out.report_state;
    assign o_report_initial = r_out.report_initial;
    assign o_machine_state  = r_out.machine_state;
    assign o_work_finished  = r_out.work_finished;

    // Solenoid fields carry nothing unless a solenoid is driven
    a_sol_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_solenoid_write) |-> (o_solenoid_index == 4'd0 && !o_solenoid_level))
        else $error("solenoid fields set without solenoid write");

    // Finishing the job always returns to ready with all solenoids released
    a_finish_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_work_finished) |->
        (o_machine_state == MODE_READY && o_release_all && o_solenoid_write))
        else $error("work finished without return to ready");

    // An accepted start job requests line 0 and enters operate
    a_start_line0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_accepted && o_line_request) |->
        (o_requested_line == 8'd0 && o_machine_state == MODE_OPERATE))
        else $error("start job did not request line zero");

    // A request is outstanding after any line request enters the result register
    a_await_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && n_out.line_request) |=> r_awaiting)
        else $error("line requested without outstanding flag");

endmodule

// ===== verif/needle_solenoid_sequencer_core_tb.sv =====
// Testbench for the needle solenoid sequencer core: directed and random event streams.
`timescale 1ns / 1ps

module needle_solenoid_sequencer_core_tb
    import nss_pkg::*;
;

    // Machine geometry, kept apart from the package so the offsets are checked too
    localparam int NEEDLES       = 200;
    localparam int STORE_BYTES   = (NEEDLES + 7) / 8;
    localparam int MARGIN_LEFT   = 12;
    localparam int MARGIN_RIGHT  = 12;
    localparam int BED_END       = 255;
    localparam int RIGHT_OFF_G   = 8;
    localparam int RIGHT_OFF_STD = 40;
    localparam int LEFT_OFF_G    = 32;
    localparam int LEFT_OFF_STD  = 16;
    localparam int RIGHT_ADJ_L   = 8;
    localparam int LEFT_ADJ_L    = 16;
    localparam int TAIL_CYCLES   = 8;

    // Codes the package leaves unnamed
    localparam logic [2:0] OP_SPARE_LO    = 3'd6;
    localparam logic [2:0] OP_SPARE_HI    = 3'd7;
    localparam logic [1:0] TRAVEL_UNKNOWN = 2'd2;
    localparam logic [1:0] HALL_NONE      = 2'd0;
    localparam logic [1:0] HALL_RIGHT     = 2'd2;
    localparam logic [1:0] KIND_K         = 2'd0;

    typedef struct {
        logic [2:0] op;
        logic [7:0] position;
        logic [1:0] travel;
        logic [1:0] hall;
        logic       belt;
        logic [1:0] kind;
        logic [7:0] line_number;
        logic [4:0] byte_index;
        logic [7:0] byte_value;
    } t_event;

    // Every input starts at a known value
    logic       i_clk           = 1'b0;
    logic       i_rst_n         = 1'b0;
    logic       i_cfg_we        = 1'b0;
    logic [1:0] i_cfg_index     = '0;
    logic [7:0] i_cfg_data      = '0;
    logic       i_valid         = 1'b0;
    logic [2:0] i_opcode        = '0;
    logic [7:0] i_position      = '0;
    logic [1:0] i_travel        = '0;
    logic [1:0] i_hall_side     = '0;
    logic       i_belt_shifted  = 1'b0;
    logic [1:0] i_carriage_kind = '0;
    logic [7:0] i_line_number   = '0;
    logic [4:0] i_byte_index    = '0;
    logic [7:0] i_byte_value    = '0;
    logic       i_ready         = 1'b0;

    logic       o_ready;
    logic       o_valid;
    logic       o_accepted;
    logic       o_solenoid_write;
    logic [3:0] o_solenoid_index;
    logic       o_solenoid_level;
    logic       o_release_all;
    logic       o_line_request;
    logic [7:0] o_requested_line;
    logic       o_report_state;
    logic       o_report_initial;
    logic [1:0] o_machine_state;
    logic       o_work_finished;

    needle_solenoid_sequencer_core uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_opcode         (i_opcode),
        .i_position       (i_position),
        .i_travel         (i_travel),
        .i_hall_side      (i_hall_side),
        .i_belt_shifted   (i_belt_shifted),
        .i_carriage_kind  (i_carriage_kind),
        .i_line_number    (i_line_number),
        .i_byte_index     (i_byte_index),
        .i_byte_value     (i_byte_value),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_accepted       (o_accepted),
        .o_solenoid_write (o_solenoid_write),
        .o_solenoid_index (o_solenoid_index),
        .o_solenoid_level (o_solenoid_level),
        .o_release_all    (o_release_all),
        .o_line_request   (o_line_request),
        .o_requested_line (o_requested_line),
        .o_report_state   (o_report_state),
        .o_report_initial (o_report_initial),
        .o_machine_state  (o_machine_state),
        .o_work_finished  (o_work_finished)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // Shadow of the sequencer: mode, line bookkeeping, bitmap and window registers
    t_mode      seq_mode;
    logic [7:0] op_last_pos;
    logic [7:0] test_last_pos;
    logic [7:0] line_no;
    bit         line_pending;
    bit         last_line_seen;
    bit         line_worked;
    logic [7:0] needle_bits [STORE_BYTES];
    logic [7:0] win_first;
    logic [7:0] win_last;
    logic       report_moves;

    // Carriage sweep used to build well-formed position streams
    int         sweep_pos   = 0;
    bit         sweep_right = 1'b1;
    logic [1:0] sweep_kind  = KIND_K;
    logic       sweep_belt  = 1'b0;

    t_result    pending_results [$];
    int         send_idle_pct  = 0;
    int         recv_stall_pct = 0;
    int         fail_count     = 0;

    // Map a carriage event to a signed needle pixel and a solenoid; 0 when out of reach
    function automatic bit map_needle(input logic [7:0] pos, input logic [1:0] travel,
                                      input logic belt, input logic [1:0] kind,
                                      output int pixel, output logic [3:0] sol);
        int p;
        int off;
        p     = int'(pos);
        pixel = 0;
        sol   = '0;
        if (travel == TRAVEL_RIGHT) begin
            off = (kind == KIND_G) ? RIGHT_OFF_G : RIGHT_OFF_STD;
            if (p < off)
                return 1'b0;
            pixel = p - off + ((kind == KIND_L) ? RIGHT_ADJ_L : 0);
            sol   = belt ? pos[3:0] + 4'd8 : pos[3:0];
            return 1'b1;
        end
        if (travel == TRAVEL_LEFT) begin
            off = (kind == KIND_G) ? LEFT_OFF_G : LEFT_OFF_STD;
            if (p > BED_END - off)
                return 1'b0;
            pixel = p - off - ((kind == KIND_L) ? LEFT_ADJ_L : 0);
            sol   = belt ? pos[3:0] : pos[3:0] + 4'd8;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void ask_next_line(inout t_result r);
        line_no          = line_no + 8'd1;
        line_pending     = 1'b1;
        r.line_request   = 1'b1;
        r.requested_line = line_no;
    endfunction

    // Carriage move while operating: drive, release, request or finish
    function automatic void carriage_move(input t_event ev, inout t_result r);
        int         pixel;
        int         lo;
        int         hi;
        logic [3:0] sol;
        if (ev.position == op_last_pos)
            return;
        op_last_pos = ev.position;
        if (report_moves) begin
            r.report_state   = 1'b1;
            r.report_initial = 1'b1;
        end
        if (!map_needle(ev.position, ev.travel, ev.belt, ev.kind, pixel, sol))
            return;
        lo               = int'(win_first) - MARGIN_LEFT;
        hi               = int'(win_last) + MARGIN_RIGHT;
        r.solenoid_write = 1'b1;
        r.solenoid_index = sol;
        r.solenoid_level = 1'b1;
        if (pixel >= lo && pixel <= hi) begin
            if (pixel >= int'(win_first) && pixel <= int'(win_last))
                line_worked = 1'b1;
            // pixels beside the store stay released
            if (pixel >= 0 && pixel < STORE_BYTES * 8)
                r.solenoid_level = needle_bits[pixel / 8][pixel % 8];
            return;
        end
        if (line_worked) begin
            line_worked = 1'b0;
            if (!line_pending && !last_line_seen) begin
                ask_next_line(r);
            end else if (last_line_seen) begin
                seq_mode        = MODE_READY;
                r.release_all   = 1'b1;
                r.work_finished = 1'b1;
            end
        end
    endfunction

    // Expected result of one transfer; advances the shadow state
    function automatic t_result sequencer_result(input t_event ev);
        t_result r;
        r = '0;
        case (ev.op)
            OP_POSITION: begin
                if (seq_mode == MODE_INIT) begin
                    if (ev.travel == TRAVEL_RIGHT && ev.hall == HALL_LEFT) begin
                        seq_mode         = MODE_READY;
                        r.release_all    = 1'b1;
                        r.report_state   = 1'b1;
                        r.report_initial = 1'b1;
                    end
                end else if (seq_mode == MODE_OPERATE) begin
                    carriage_move(ev, r);
                end else if (seq_mode == MODE_TEST) begin
                    if (ev.position != test_last_pos) begin
                        test_last_pos  = ev.position;
                        r.report_state = 1'b1;
                    end
                end
            end
            OP_START_JOB: begin
                if (seq_mode == MODE_READY && int'(win_last) < NEEDLES &&
                    win_first < win_last) begin
                    seq_mode       = MODE_OPERATE;
                    line_no        = 8'd255;
                    line_pending   = 1'b0;
                    last_line_seen = 1'b0;
                    line_worked    = 1'b0;
                    r.accepted     = 1'b1;
                    ask_next_line(r);
                end
            end
            OP_START_TEST: begin
                if (seq_mode == MODE_INIT || seq_mode == MODE_READY) begin
                    seq_mode   = MODE_TEST;
                    r.accepted = 1'b1;
                end
            end
            OP_LINE: begin
                if (line_pending) begin
                    if (ev.line_number == line_no) begin
                        line_pending = 1'b0;
                        r.accepted   = 1'b1;
                    end else begin
                        r.line_request   = 1'b1;
                        r.requested_line = line_no;
                    end
                end
            end
            OP_LAST_LINE: last_line_seen = 1'b1;
            OP_WRITE_BYTE: begin
                if (int'(ev.byte_index) < STORE_BYTES)
                    needle_bits[ev.byte_index] = ev.byte_value;
            end
            default: ;
        endcase
        r.machine_state = seq_mode;
        return r;
    endfunction

    function automatic t_event random_event();
        t_event ev;
        ev.op          = OP_POSITION;
        ev.position    = 8'($urandom);
        ev.travel      = 2'($urandom_range(2));
        ev.hall        = 2'($urandom_range(2));
        ev.belt        = 1'($urandom);
        ev.kind        = 2'($urandom_range(2));
        ev.line_number = 8'($urandom);
        ev.byte_index  = 5'($urandom_range(STORE_BYTES - 1));
        ev.byte_value  = 8'($urandom);
        return ev;
    endfunction

    // Advance the carriage a few steps; turn round at either end of the bed
    function automatic t_event sweep_step(input t_event ev);
        int stride;
        stride    = $urandom_range(4);
        sweep_pos = sweep_pos + (sweep_right ? stride : -stride);
        if (sweep_pos >= BED_END || sweep_pos <= 0) begin
            sweep_pos   = (sweep_pos >= BED_END) ? BED_END : 0;
            sweep_right = (sweep_pos == 0);
            sweep_kind  = 2'($urandom_range(2));
            sweep_belt  = 1'($urandom);
        end
        ev.position = 8'(sweep_pos);
        ev.travel   = sweep_right ? TRAVEL_RIGHT : TRAVEL_LEFT;
        if ($urandom_range(99) < 5)
            ev.travel = TRAVEL_UNKNOWN;
        ev.kind = sweep_kind;
        ev.belt = sweep_belt;
        return ev;
    endfunction

    // Next random event, shaped by the shadow mode so that jobs run through many lines
    function automatic t_event next_event();
        t_event ev;
        int     roll;
        ev   = random_event();
        roll = $urandom_range(99);
        case (seq_mode)
            MODE_INIT: begin
                if (roll < 50) begin
                    ev.travel = TRAVEL_RIGHT;
                    ev.hall   = HALL_LEFT;
                end
            end
            MODE_READY: begin
                // no test start here: test mode is only left by reset
                if (roll < 60) begin
                    ev.op = OP_START_JOB;
                end else begin
                    case ($urandom_range(3))
                        0: ev.op = OP_POSITION;
                        1: begin
                            ev.op = OP_LINE;
                            if (roll < 80)
                                ev.line_number = line_no;
                        end
                        2: ev.op = OP_LAST_LINE;
                        default: ev.op = OP_WRITE_BYTE;
                    endcase
                end
            end
            MODE_OPERATE: begin
                if (line_pending && roll < 40) begin
                    ev.op = OP_LINE;
                    if (roll < 36)
                        ev.line_number = line_no;
                end else if (roll < 90) begin
                    ev = sweep_step(ev);
                end else if (roll < 92) begin
                    ev.op = OP_LAST_LINE;
                end else begin
                    case ($urandom_range(3))
                        0: ev.op = OP_START_JOB;
                        1: ev.op = OP_START_TEST;
                        2: ev.op = OP_LINE;
                        default: ev.op = OP_WRITE_BYTE;
                    endcase
                end
            end
            default: ev.op = 3'($urandom_range(int'(OP_WRITE_BYTE)));
        endcase
        return ev;
    endfunction

    // Present one event; valid stays high into the next call unless a gap is drawn
    task automatic send_item(input t_event ev);
        if ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            do
                @(posedge i_clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        i_valid         <= 1'b1;
        i_opcode        <= ev.op;
        i_position      <= ev.position;
        i_travel        <= ev.travel;
        i_hall_side     <= ev.hall;
        i_belt_shifted  <= ev.belt;
        i_carriage_kind <= ev.kind;
        i_line_number   <= ev.line_number;
        i_byte_index    <= ev.byte_index;
        i_byte_value    <= ev.byte_value;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
        pending_results.push_back(sequencer_result(ev));
    endtask

    task automatic send_command(input logic [2:0] op, input logic [7:0] number,
                                input logic [4:0] index, input logic [7:0] value);
        t_event ev;
        ev             = random_event();
        ev.op          = op;
        ev.line_number = number;
        ev.byte_index  = index;
        ev.byte_value  = value;
        send_item(ev);
    endtask

    task automatic send_position(input logic [7:0] pos, input logic [1:0] travel,
                                 input logic [1:0] hall, input logic [1:0] kind,
                                 input logic belt);
        t_event ev;
        ev          = random_event();
        ev.position = pos;
        ev.travel   = travel;
        ev.hall     = hall;
        ev.kind     = kind;
        ev.belt     = belt;
        send_item(ev);
    endtask

    // Drop valid and wait for every outstanding result, then let the pipe settle
    task automatic drain_pipeline();
        i_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    // Write all three window registers on consecutive edges; pipeline must be empty
    task automatic load_window(input logic [7:0] first, input logic [7:0] last,
                               input logic every);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_FIRST_NEEDLE;
        i_cfg_data  <= first;
        @(posedge i_clk);
        i_cfg_index <= CFG_LAST_NEEDLE;
        i_cfg_data  <= last;
        @(posedge i_clk);
        i_cfg_index <= CFG_REPORT_MOVE;
        i_cfg_data  <= {7'd0, every};
        @(posedge i_clk);
        i_cfg_we     <= 1'b0;
        win_first    = first;
        win_last     = last;
        report_moves = every;
    endtask

    // Fill every bitmap byte so that no pixel read touches an unwritten entry
    task automatic test_bitmap_fill();
        send_command(OP_WRITE_BYTE, 8'd0, 5'd0, 8'hFF);
        for (int i = 1; i < STORE_BYTES - 1; i++)
            send_command(OP_WRITE_BYTE, 8'd0, 5'(i), 8'($urandom));
        send_command(OP_WRITE_BYTE, 8'd0, 5'(STORE_BYTES - 1), 8'h00);
        // addresses past the store are dropped
        send_command(OP_WRITE_BYTE, 8'd0, 5'(STORE_BYTES), 8'h5A);
        send_command(OP_WRITE_BYTE, 8'd0, 5'd31, 8'hA5);
    endtask

    // Init: only a rightward move over the left hall sensor leaves it
    task automatic test_init_mode();
        send_position(8'd40, TRAVEL_LEFT, HALL_LEFT, KIND_K, 1'b0);
        send_position(8'd41, TRAVEL_RIGHT, HALL_RIGHT, KIND_K, 1'b0);
        send_position(8'd42, TRAVEL_RIGHT, HALL_NONE, KIND_K, 1'b0);
        send_command(OP_START_JOB, 8'd0, 5'd0, 8'd0);
        send_command(OP_LINE, 8'd0, 5'd0, 8'd0);
        send_command(OP_LAST_LINE, 8'd0, 5'd0, 8'd0);
        send_command(OP_SPARE_LO, 8'd0, 5'd0, 8'd0);
        send_command(OP_SPARE_HI, 8'd0, 5'd0, 8'd0);
        send_position(8'd43, TRAVEL_RIGHT, HALL_LEFT, KIND_K, 1'b0);
    endtask

    // Start job needs first < last and last below the needle count
    task automatic test_start_rules();
        drain_pipeline();
        load_window(8'd50, 8'd50, 1'b0);
        send_command(OP_START_JOB, 8'd0, 5'd0, 8'd0);
        drain_pipeline();
        load_window(8'd10, 8'd200, 1'b0);
        send_command(OP_START_JOB, 8'd0, 5'd0, 8'd0);
        drain_pipeline();
        load_window(8'd0, 8'd199, 1'b1);
        send_command(OP_START_JOB, 8'd0, 5'd0, 8'd0);
    endtask

    // One hand-built job across the full window, ending on the last line
    task automatic test_operate_cycle();
        send_command(OP_LINE, 8'd7, 5'd0, 8'd0);      // wrong number: ask again
        send_command(OP_LINE, 8'd0, 5'd0, 8'd0);
        send_command(OP_LINE, 8'd0, 5'd0, 8'd0);      // nothing outstanding
        send_command(OP_START_TEST, 8'd0, 5'd0, 8'd0);
        send_command(OP_START_JOB, 8'd0, 5'd0, 8'd0);
        send_position(8'd0, TRAVEL_RIGHT, HALL_NONE, KIND_K, 1'b0);   // no move
        send_position(8'd30, TRAVEL_RIGHT, HALL_NONE, KIND_K, 1'b0);  // out of reach
        send_position(8'd100, TRAVEL_RIGHT, HALL_NONE, KIND_K, 1'b0);
        send_position(8'd100, TRAVEL_RIGHT, HALL_NONE, KIND_K, 1'b0);
        send_position(8'd101, TRAVEL_UNKNOWN, HALL_NONE, KIND_K, 1'b0);
        send_position(8'd255, TRAVEL_RIGHT, HALL_RIGHT, KIND_K, 1'b0);
        send_command(OP_LINE, 8'd1, 5'd0, 8'd0);
        send_position(8'd250, TRAVEL_LEFT, HALL_NONE, KIND_K, 1'b0);  // out of reach
        send_position(8'd10, TRAVEL_LEFT, HALL_NONE, KIND_K, 1'b0);   // below the store
        send_position(8'd0, TRAVEL_LEFT, HALL_NONE, KIND_L, 1'b0);    // left of window
        send_position(8'd239, TRAVEL_LEFT, HALL_NONE, KIND_G, 1'b1);  // out of reach
        send_position(8'd8, TRAVEL_RIGHT, HALL_NONE, KIND_G, 1'b1);
        send_position(8'd200, TRAVEL_RIGHT, HALL_NONE, KIND_L, 1'b0);
        send_command(OP_LAST_LINE, 8'd0, 5'd0, 8'd0);
        send_position(8'd252, TRAVEL_RIGHT, HALL_NONE, KIND_K, 1'b1); // job done
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct,
                             input logic [7:0] first, input logic [7:0] last,
                             input logic every, input int count);
        drain_pipeline();
        load_window(first, last, every);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (count) send_item(next_event());
    endtask

    task automatic test_random_sweeps();
        logic [7:0] first;
        first = 8'($urandom_range(NEEDLES - 3));
        run_phase(0, 0, 8'd0, 8'd199, 1'b1, 470);
        run_phase(85, 0, 8'd198, 8'd199, 1'b0, 470);
        run_phase(0, 85, first, 8'($urandom_range(NEEDLES - 1, int'(first) + 1)),
                  1'($urandom), 470);
        run_phase(30, 30, 8'd60, 8'd130, 1'b1, 470);
    endtask

    // Test mode has no way out, so it comes last: finish the job, then enter it
    task automatic test_test_mode();
        int guard;
        guard = 0;
        while (seq_mode != MODE_READY && guard < 3000) begin
            if (seq_mode == MODE_OPERATE && !last_line_seen)
                send_command(OP_LAST_LINE, 8'd0, 5'd0, 8'd0);
            else
                send_item(next_event());
            guard++;
        end
        send_command(OP_START_TEST, 8'd0, 5'd0, 8'd0);
        repeat (40) send_item(next_event());
    endtask

    // Receiver back-pressure
    always @(posedge i_clk)
        i_ready <= ($urandom_range(99) >= recv_stall_pct);

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    // Compare each result transfer with the oldest expectation
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                $error("result transfer with nothing expected");
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("accepted", 8'(want.accepted), 8'(o_accepted));
                check_field("solenoid_write", 8'(want.solenoid_write),
                            8'(o_solenoid_write));
                check_field("solenoid_index", 8'(want.solenoid_index),
                            8'(o_solenoid_index));
                check_field("solenoid_level", 8'(want.solenoid_level),
                            8'(o_solenoid_level));
                check_field("release_all", 8'(want.release_all), 8'(o_release_all));
                check_field("line_request", 8'(want.line_request), 8'(o_line_request));
                check_field("requested_line", want.requested_line, o_requested_line);
                check_field("report_state", 8'(want.report_state), 8'(o_report_state));
                check_field("report_initial", 8'(want.report_initial),
                            8'(o_report_initial));
                check_field("machine_state", 8'(want.machine_state),
                            8'(o_machine_state));
                check_field("work_finished", 8'(want.work_finished),
                            8'(o_work_finished));
            end
        end
    end

    initial begin
        seq_mode       = MODE_INIT;
        op_last_pos    = '0;
        test_last_pos  = '0;
        line_no        = 8'd255;
        line_pending   = 1'b0;
        last_line_seen = 1'b0;
        line_worked    = 1'b0;
        win_first      = '0;
        win_last       = '0;
        report_moves   = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_bitmap_fill();
        test_init_mode();
        test_start_rules();
        test_operate_cycle();
        test_random_sweeps();
        drain_pipeline();
        load_window(8'd60, 8'd130, 1'b1);
        test_test_mode();
        drain_pipeline();
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Hard stop, well beyond the slowest legal run
    initial begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
